FILE: rtl/assert_macros.svh
// Assertion helpers shared by the resolver modules.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CIR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("contact resolver assertion failed");

// Next-cycle implication
`define CIR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("contact resolver assertion failed");

`endif

FILE: rtl/cir_pkg.sv
package cir_pkg;

    localparam int unsigned QW     = 32;
    localparam int unsigned FRAC_W = 17;
    localparam int unsigned SHW    = 48;

    localparam logic [FRAC_W-1:0] CORR_FRAC_RESET = 17'd52429;

    typedef enum logic [1:0] {
        OC_PASS    = 2'd0,
        OC_CORRECT = 2'd1,
        OC_IMPULSE = 2'd2
    } cir_outcome_t;

    // One contact as it enters the block
    typedef struct packed {
        logic [63:0]        vel_a;
        logic [63:0]        vel_b;
        logic [63:0]        pos_a;
        logic [63:0]        pos_b;
        logic [63:0]        contact_normal;
        logic signed [31:0] penetration;
        logic [16:0]        restitution_a;
        logic [16:0]        restitution_b;
        logic               static_a;
        logic               static_b;
        logic               is_trigger;
        logic               has_contact;
    } cir_in_t;

    // Hand-off from the front half to the back half
    typedef struct packed {
        logic [63:0]           vel_a;
        logic [63:0]           vel_b;
        logic [63:0]           pos_a;
        logic [63:0]           pos_b;
        logic signed [31:0]    nx;
        logic signed [31:0]    ny;
        logic signed [31:0]    vn;
        logic signed [SHW-1:0] cx;
        logic signed [SHW-1:0] cy;
        logic [16:0]           e;
        logic                  both;
        logic                  sa;
        logic                  sb;
        logic                  active;
        logic                  corr;
    } cir_mid_t;

    // One result as it leaves the block
    typedef struct packed {
        logic [63:0]  new_vel_a;
        logic [63:0]  new_vel_b;
        logic [63:0]  new_pos_a;
        logic [63:0]  new_pos_b;
        cir_outcome_t outcome;
    } cir_out_t;

    // Clamp a wide signed value to the Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/cir_front.sv
module cir_front
    import cir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [16:0]       corr_frac,
    input  logic              in_valid,
    output logic              in_ready,
    input  cir_in_t           in_item,
    output logic              mid_valid,
    input  logic              mid_ready,
    output cir_mid_t          mid_item
);

`include "assert_macros.svh"

    // Stage 1 registers
    logic               v1_reg;
    cir_in_t            item1_reg, item1_next;
    logic signed [31:0] dvx1_reg, dvx1_next;
    logic signed [31:0] dvy1_reg, dvy1_next;
    logic [16:0]        e1_reg, e1_next;
    logic signed [49:0] cprod1_reg, cprod1_next;
    logic               active1_reg, active1_next;
    logic               both1_reg, both1_next;
    logic               corr1_reg, corr1_next;

    // Stage 2 registers
    logic               v2_reg;
    cir_in_t            item2_reg;
    logic [16:0]        e2_reg;
    logic               active2_reg, both2_reg, corr2_reg;
    logic signed [63:0] pdx2_reg, pdx2_next;
    logic signed [63:0] pdy2_reg, pdy2_next;
    logic signed [63:0] ncx2_reg, ncx2_next;
    logic signed [63:0] ncy2_reg, ncy2_next;

    // Stage 3 registers
    logic               v3_reg;
    cir_mid_t           mid3_reg, mid3_next;

    logic en1, en2, en3;

    // Advance a stage when it is empty or the next one moves
    assign en3      = !v3_reg || mid_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: velocity difference, restitution, penetration product
    always_comb
    begin
        logic signed [31:0] vax, vay, vbx, vby;
        logic signed [32:0] dx, dy;
        logic               sa, sb;
        vax = in_item.vel_a[63:32];
        vay = in_item.vel_a[31:0];
        vbx = in_item.vel_b[63:32];
        vby = in_item.vel_b[31:0];
        sa  = in_item.static_a;
        sb  = in_item.static_b;
        dx  = 33'(vax) - 33'(vbx);
        dy  = 33'(vay) - 33'(vby);
        dvx1_next    = sat32(64'(dx));
        dvy1_next    = sat32(64'(dy));
        e1_next      = (in_item.restitution_a < in_item.restitution_b) ?
                       in_item.restitution_a : in_item.restitution_b;
        cprod1_next  = in_item.penetration * $signed({1'b0, corr_frac});
        active1_next = !in_item.is_trigger && in_item.has_contact && !(sa && sb);
        both1_next   = !sa && !sb;
        corr1_next   = active1_next && (in_item.penetration > 32'sd0);
        item1_next   = in_item;
    end

    // Stage 2: normal projections and correction along the normal
    always_comb
    begin
        logic signed [31:0] nx, ny, c;
        nx = item1_reg.contact_normal[63:32];
        ny = item1_reg.contact_normal[31:0];
        c  = sat32(64'(cprod1_reg >>> 16));
        pdx2_next = dvx1_reg * nx;
        pdy2_next = dvy1_reg * ny;
        ncx2_next = nx * c;
        ncy2_next = ny * c;
    end

    // Stage 3: normal velocity and position shift
    always_comb
    begin
        logic signed [63:0] sum;
        sum = 64'(pdx2_reg >>> 16) + 64'(pdy2_reg >>> 16);
        mid3_next.vel_a  = item2_reg.vel_a;
        mid3_next.vel_b  = item2_reg.vel_b;
        mid3_next.pos_a  = item2_reg.pos_a;
        mid3_next.pos_b  = item2_reg.pos_b;
        mid3_next.nx     = item2_reg.contact_normal[63:32];
        mid3_next.ny     = item2_reg.contact_normal[31:0];
        mid3_next.vn     = sat32(sum);
        mid3_next.cx     = both2_reg ? SHW'(ncx2_reg >>> 17) : SHW'(ncx2_reg >>> 16);
        mid3_next.cy     = both2_reg ? SHW'(ncy2_reg >>> 17) : SHW'(ncy2_reg >>> 16);
        mid3_next.e      = e2_reg;
        mid3_next.both   = both2_reg;
        mid3_next.sa     = item2_reg.static_a;
        mid3_next.sb     = item2_reg.static_b;
        mid3_next.active = active2_reg;
        mid3_next.corr   = corr2_reg;
    end

    // Hold valid bits per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            item1_reg   <= item1_next;
            dvx1_reg    <= dvx1_next;
            dvy1_reg    <= dvy1_next;
            e1_reg      <= e1_next;
            cprod1_reg  <= cprod1_next;
            active1_reg <= active1_next;
            both1_reg   <= both1_next;
            corr1_reg   <= corr1_next;
        end
        if (en2)
        begin
            item2_reg   <= item1_reg;
            e2_reg      <= e1_reg;
            active2_reg <= active1_reg;
            both2_reg   <= both1_reg;
            corr2_reg   <= corr1_reg;
            pdx2_reg    <= pdx2_next;
            pdy2_reg    <= pdy2_next;
            ncx2_reg    <= ncx2_next;
            ncy2_reg    <= ncy2_next;
        end
        if (en3)
            mid3_reg <= mid3_next;
    end

    assign mid_valid = v3_reg;
    assign mid_item  = mid3_reg;

    `CIR_ASSERT_NXT(a_accept_lands, in_valid && in_ready, v1_reg)
    `CIR_ASSERT_NXT(a_stall_keeps, mid_valid && !mid_ready, mid_valid)

endmodule

FILE: rtl/cir_back.sv
module cir_back
    import cir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mid_valid,
    output logic     mid_ready,
    input  cir_mid_t mid_item,
    output logic     out_valid,
    input  logic     out_ready,
    output cir_out_t out_item
);

`include "assert_macros.svh"

    // Stage 4 registers
    logic               v4_reg;
    logic [63:0]        vel_a4_reg, vel_b4_reg;
    logic [63:0]        pos_a4_reg, pos_a4_next;
    logic [63:0]        pos_b4_reg, pos_b4_next;
    logic signed [31:0] nx4_reg, ny4_reg;
    logic signed [31:0] j4_reg, j4_next;
    logic               imp4_reg, imp4_next;
    logic               corr4_reg, sa4_reg, sb4_reg;

    // Stage 5 registers
    logic               v5_reg;
    logic [63:0]        vel_a5_reg, vel_b5_reg, pos_a5_reg, pos_b5_reg;
    logic signed [63:0] ixp5_reg, ixp5_next;
    logic signed [63:0] iyp5_reg, iyp5_next;
    logic               imp5_reg, corr5_reg, sa5_reg, sb5_reg;

    // Stage 6 registers (output)
    logic               v6_reg;
    cir_out_t           out6_reg, out6_next;
    logic               sa6_reg, sb6_reg;

    logic en4, en5, en6;

    assign en6       = !v6_reg || out_ready;
    assign en5       = !v5_reg || en6;
    assign en4       = !v4_reg || en5;
    assign mid_ready = en4;

    // Stage 4: impulse magnitude and positional correction
    always_comb
    begin
        logic [17:0]        k;
        logic signed [50:0] prod;
        logic signed [51:0] neg;
        logic signed [48:0] pax, pay, pbx, pby;
        k    = 18'(mid_item.e) + 18'd65536;
        prod = $signed({1'b0, k}) * mid_item.vn;
        neg  = -(52'(prod));
        j4_next   = mid_item.both ? sat32(64'(neg >>> 17)) : sat32(64'(neg >>> 16));
        imp4_next = mid_item.active && (mid_item.vn > 32'sd0);
        pax = 49'($signed(mid_item.pos_a[63:32])) - 49'(mid_item.cx);
        pay = 49'($signed(mid_item.pos_a[31:0]))  - 49'(mid_item.cy);
        pbx = 49'($signed(mid_item.pos_b[63:32])) + 49'(mid_item.cx);
        pby = 49'($signed(mid_item.pos_b[31:0]))  + 49'(mid_item.cy);
        if (mid_item.corr && !mid_item.sa)
            pos_a4_next = {sat32(64'(pax)), sat32(64'(pay))};
        else
            pos_a4_next = mid_item.pos_a;
        if (mid_item.corr && !mid_item.sb)
            pos_b4_next = {sat32(64'(pbx)), sat32(64'(pby))};
        else
            pos_b4_next = mid_item.pos_b;
    end

    // Stage 5: impulse components
    always_comb
    begin
        ixp5_next = nx4_reg * j4_reg;
        iyp5_next = ny4_reg * j4_reg;
    end

    // Stage 6: apply impulse and grade the outcome
    always_comb
    begin
        logic signed [48:0] ax, ay, bx, by;
        ax = 49'($signed(vel_a5_reg[63:32])) + 49'(ixp5_reg >>> 16);
        ay = 49'($signed(vel_a5_reg[31:0]))  + 49'(iyp5_reg >>> 16);
        bx = 49'($signed(vel_b5_reg[63:32])) - 49'(ixp5_reg >>> 16);
        by = 49'($signed(vel_b5_reg[31:0]))  - 49'(iyp5_reg >>> 16);
        if (imp5_reg && !sa5_reg)
            out6_next.new_vel_a = {sat32(64'(ax)), sat32(64'(ay))};
        else
            out6_next.new_vel_a = vel_a5_reg;
        if (imp5_reg && !sb5_reg)
            out6_next.new_vel_b = {sat32(64'(bx)), sat32(64'(by))};
        else
            out6_next.new_vel_b = vel_b5_reg;
        out6_next.new_pos_a = pos_a5_reg;
        out6_next.new_pos_b = pos_b5_reg;
        if (imp5_reg)
            out6_next.outcome = OC_IMPULSE;
        else if (corr5_reg)
            out6_next.outcome = OC_CORRECT;
        else
            out6_next.outcome = OC_PASS;
    end

    // Hold valid bits per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                v4_reg <= mid_valid;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                v6_reg <= v5_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            vel_a4_reg <= mid_item.vel_a;
            vel_b4_reg <= mid_item.vel_b;
            pos_a4_reg <= pos_a4_next;
            pos_b4_reg <= pos_b4_next;
            nx4_reg    <= mid_item.nx;
            ny4_reg    <= mid_item.ny;
            j4_reg     <= j4_next;
            imp4_reg   <= imp4_next;
            corr4_reg  <= mid_item.corr;
            sa4_reg    <= mid_item.sa;
            sb4_reg    <= mid_item.sb;
        end
        if (en5)
        begin
            vel_a5_reg <= vel_a4_reg;
            vel_b5_reg <= vel_b4_reg;
            pos_a5_reg <= pos_a4_reg;
            pos_b5_reg <= pos_b4_reg;
            ixp5_reg   <= ixp5_next;
            iyp5_reg   <= iyp5_next;
            imp5_reg   <= imp4_reg;
            corr5_reg  <= corr4_reg;
            sa5_reg    <= sa4_reg;
            sb5_reg    <= sb4_reg;
        end
        if (en6)
        begin
            out6_reg <= out6_next;
            sa6_reg  <= sa5_reg;
            sb6_reg  <= sb5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_item  = out6_reg;

    `CIR_ASSERT_IMP(a_no_impulse_both_static, out_valid && out_item.outcome == OC_IMPULSE, !(sa6_reg && sb6_reg))

endmodule

FILE: rtl/contact_impulse_resolver.sv
// Channel    Dir  Contents
// s_axis     in   one contact: vectors, depth, restitutions, body flags
// m_axis     out  updated velocities and positions, outcome code
// cfg_wr     in   correction fraction, Q1.16
//
// One item is taken per cycle when nothing stalls.
// The six stages are velocity difference, normal projections, normal velocity and shift,
// impulse scale and position update, impulse components, then the saturating adds.
// Reset clears every stage valid bit and loads the correction fraction
// with 52429 (about 0.8).
// A stall at m_axis holds each full stage; empty stages still fill.
module contact_impulse_resolver
    import cir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vel_a, vel_b, pos_a, pos_b, contact_normal, penetration,
    // restitution_a, restitution_b, zero pad to 392 bits
    input  logic [391:0] s_axis_tdata,
    // static_a, static_b, is_trigger, has_contact
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_vel_a, new_vel_b, new_pos_a, new_pos_b
    output logic [255:0] m_axis_tdata,
    // outcome
    output logic [1:0]   m_axis_tuser
);

    logic [16:0] corr_frac_reg;
    cir_in_t     in_item;
    cir_mid_t    mid_item;
    cir_out_t    out_item;
    logic        mid_valid, mid_ready;

    // Hold the correction fraction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            corr_frac_reg <= CORR_FRAC_RESET;
        else if (cfg_wr_en)
            corr_frac_reg <= cfg_wr_data;
    end

    // Unpack the incoming item
    always_comb
    begin
        in_item.vel_a          = s_axis_tdata[63:0];
        in_item.vel_b          = s_axis_tdata[127:64];
        in_item.pos_a          = s_axis_tdata[191:128];
        in_item.pos_b          = s_axis_tdata[255:192];
        in_item.contact_normal = s_axis_tdata[319:256];
        in_item.penetration    = s_axis_tdata[351:320];
        in_item.restitution_a  = s_axis_tdata[368:352];
        in_item.restitution_b  = s_axis_tdata[385:369];
        in_item.static_a       = s_axis_tuser[0];
        in_item.static_b       = s_axis_tuser[1];
        in_item.is_trigger     = s_axis_tuser[2];
        in_item.has_contact    = s_axis_tuser[3];
    end

    cir_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .corr_frac (corr_frac_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item)
    );

    cir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_item  (mid_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // Pack the result
    assign m_axis_tdata = {out_item.new_pos_b, out_item.new_pos_a,
                           out_item.new_vel_b, out_item.new_vel_a};
    assign m_axis_tuser = out_item.outcome;

endmodule
